// ----- rtl/core/pces_pkg.sv -----
package pces_pkg;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int BYTE_BITS = 8;

   typedef enum logic [1:0] {
      REG_BITS_PER_ELEMENT = 2'd0,
      REG_MATCH_KEY        = 2'd1,
      REG_ELEMENT_COUNT    = 2'd2
   } pces_reg_type;

   typedef struct packed {
      logic [4:0]  bits_per_element;
      logic [15:0] match_key;
      logic [31:0] element_count;
   } pces_cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } pces_queue_status_type;

   function automatic logic [3:0] popcount8(input logic [BYTE_BITS-1:0] flags);
      logic [3:0] sum;
      sum = 4'd0;
      for (int i = 0; i < BYTE_BITS; i++) begin
         sum = sum + 4'(flags[i]);
      end
      return sum;
   endfunction

endpackage

// ----- rtl/core/pces_front.sv -----
module pces_front #(
   parameter int WORD_BITS = 64,
   parameter int MAX_ELEMENT_BITS = 16,
   localparam int COUNT_BITS = $clog2(WORD_BITS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pces_pkg::pces_cfg_type        cfg,
   input  logic                          scan_clear,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [63:0]                   req_packed_word,
   input  pces_pkg::pces_queue_status_type q_status,
   output logic                          q_push,
   output logic [WORD_BITS-1:0]          q_match,
   output logic [COUNT_BITS-1:0]         q_take,
   output logic                          q_last
);
   import pces_pkg::*;

   localparam int STREAM_BITS = WORD_BITS + MAX_ELEMENT_BITS - 1;
   localparam int CARRY_BITS = MAX_ELEMENT_BITS - 1;
   localparam int CARRY_CNT_BITS = $clog2(MAX_ELEMENT_BITS);
   localparam int WIDTH_BITS = $clog2(MAX_ELEMENT_BITS + 1);
   localparam int TOTAL_BITS = $clog2(STREAM_BITS + 1);

   logic [WIDTH_BITS-1:0]       elem_width;
   logic [MAX_ELEMENT_BITS-1:0] elem_mask;
   logic [MAX_ELEMENT_BITS-1:0] elem_value;
   logic [CARRY_BITS-1:0]       carry_bits_ff, carry_bits_in;
   logic [CARRY_CNT_BITS-1:0]   carry_count_ff, carry_count_in;
   logic [31:0]                 left_ff, left_in, left_eff;
   logic                        start_ff, start_in;
   logic                        s1_valid_ff, s1_valid_in;
   logic [STREAM_BITS-1:0]      s1_stream_ff, s1_stream_in;
   logic [COUNT_BITS-1:0]       s1_take_ff, s1_take_in;
   logic                        s1_last_ff, s1_last_in;
   logic [STREAM_BITS-1:0]      stream;
   logic [TOTAL_BITS-1:0]       total, consumed;
   logic [COUNT_BITS-1:0]       word_elems;
   logic                        accept, advance, scan_end;

   always_comb begin
      if (cfg.bits_per_element == 5'd0) begin
         elem_width = WIDTH_BITS'(1);
      end else if (int'(cfg.bits_per_element) > MAX_ELEMENT_BITS) begin
         elem_width = WIDTH_BITS'(MAX_ELEMENT_BITS);
      end else begin
         elem_width = WIDTH_BITS'(cfg.bits_per_element);
      end
   end

   assign q_push    = s1_valid_ff && !q_status.full;
   assign advance   = !s1_valid_ff || !q_status.full;
   assign req_stall = s1_valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;

   assign stream = (STREAM_BITS'(req_packed_word[WORD_BITS-1:0]) << carry_count_ff)
                   | STREAM_BITS'(carry_bits_ff);
   assign total  = TOTAL_BITS'(carry_count_ff) + TOTAL_BITS'(WORD_BITS);

   always_comb begin
      word_elems = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if ((i + 1) * int'(elem_width) <= int'(total)) begin
            word_elems = COUNT_BITS'(i + 1);
         end
      end
   end

   assign consumed = TOTAL_BITS'(int'(word_elems) * int'(elem_width));
   assign left_eff = start_ff ? cfg.element_count : left_ff;
   assign scan_end = (left_eff != 32'd0) && (left_eff <= 32'(word_elems));

   always_comb begin
      carry_bits_in  = carry_bits_ff;
      carry_count_in = carry_count_ff;
      left_in        = left_ff;
      start_in       = start_ff;
      s1_valid_in    = advance ? accept : s1_valid_ff;
      s1_stream_in   = s1_stream_ff;
      s1_take_in     = s1_take_ff;
      s1_last_in     = s1_last_ff;
      if (accept) begin
         s1_stream_in = stream;
         if (scan_end) begin
            s1_take_in     = left_eff[COUNT_BITS-1:0];
            s1_last_in     = 1'b1;
            carry_bits_in  = '0;
            carry_count_in = '0;
            start_in       = 1'b1;
         end else begin
            s1_take_in     = word_elems;
            s1_last_in     = 1'b0;
            carry_bits_in  = CARRY_BITS'(stream >> consumed);
            carry_count_in = CARRY_CNT_BITS'(total - consumed);
            left_in        = left_eff - 32'(word_elems);
            start_in       = 1'b0;
         end
      end
      if (scan_clear) begin
         carry_bits_in  = '0;
         carry_count_in = '0;
         start_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_bits_ff  <= '0;
         carry_count_ff <= '0;
         start_ff       <= 1'b1;
         s1_valid_ff    <= 1'b0;
      end else begin
         carry_bits_ff  <= carry_bits_in;
         carry_count_ff <= carry_count_in;
         start_ff       <= start_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      s1_stream_ff <= s1_stream_in;
      s1_take_ff   <= s1_take_in;
      s1_last_ff   <= s1_last_in;
   end

   assign elem_mask = ~({MAX_ELEMENT_BITS{1'b1}} << elem_width);

   always_comb begin
      elem_value = '0;
      q_match    = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         elem_value = MAX_ELEMENT_BITS'(s1_stream_ff >> (i * int'(elem_width))) & elem_mask;
         q_match[i] = (COUNT_BITS'(i) < s1_take_ff)
                      && (32'(elem_value) == 32'(cfg.match_key));
      end
   end

   assign q_take = s1_take_ff;
   assign q_last = s1_last_ff;

endmodule

// ----- rtl/core/pces_queue.sv -----
module pces_queue #(
   parameter int DATA_BITS = 72
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic [DATA_BITS-1:0]            push_data,
   input  logic                            pop,
   output logic [DATA_BITS-1:0]            pop_data,
   output pces_pkg::pces_queue_status_type status
);
   import pces_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_BITS-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + FILL_BITS'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = slot_ff[rd_ptr_ff];
   assign status.full  = (fill_ff == FILL_BITS'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);

endmodule

// ----- rtl/core/pces_back.sv -----
module pces_back #(
   parameter int WORD_BITS = 64,
   localparam int COUNT_BITS = $clog2(WORD_BITS + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            scan_clear,
   input  pces_pkg::pces_queue_status_type q_status,
   output logic                            q_pop,
   input  logic [WORD_BITS-1:0]            q_match,
   input  logic [COUNT_BITS-1:0]           q_take,
   input  logic                            q_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_match_byte,
   output logic [31:0]                     rsp_hit_total,
   output logic                            rsp_last
);
   import pces_pkg::*;

   logic                  work_valid_ff, work_valid_in;
   logic [WORD_BITS-1:0]  work_bits_ff, work_bits_in;
   logic [COUNT_BITS-1:0] work_left_ff, work_left_in;
   logic                  work_last_ff, work_last_in;
   logic [2:0]            fill_ff, fill_in;
   logic [7:0]            pending_ff, pending_in;
   logic [31:0]           hits_ff, hits_in;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_byte_ff, out_byte_in;
   logic [31:0]           out_hits_ff, out_hits_in;
   logic                  out_last_ff, out_last_in;

   logic        out_free, step, drained, finish, full_byte, emit, emit_last, entry_done;
   logic [3:0]  room, take, total;
   logic [14:0] piece;
   logic [15:0] window;
   logic [31:0] emit_hits;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign step       = work_valid_ff && out_free;
   assign room       = 4'd15 - 4'(fill_ff);
   assign take       = (work_left_ff < COUNT_BITS'(room)) ? 4'(work_left_ff) : room;
   assign piece      = work_bits_ff[14:0] & ~(15'h7fff << take);
   assign window     = 16'(pending_ff) | (16'(piece) << fill_ff);
   assign total      = 4'(fill_ff) + take;
   assign drained    = (COUNT_BITS'(take) == work_left_ff);
   assign finish     = work_last_ff && drained;
   assign full_byte  = (total >= 4'd8);
   assign emit       = step && (full_byte || finish);
   assign emit_last  = finish && (total <= 4'd8);
   assign emit_hits  = hits_ff + 32'(popcount8(window[7:0]));
   assign entry_done = drained && (!work_last_ff || emit_last);
   assign q_pop      = !q_status.empty && (!work_valid_ff || (step && entry_done));

   always_comb begin
      work_valid_in = work_valid_ff;
      work_bits_in  = work_bits_ff;
      work_left_in  = work_left_ff;
      work_last_in  = work_last_ff;
      fill_in       = fill_ff;
      pending_in    = pending_ff;
      hits_in       = hits_ff;
      if (step) begin
         work_bits_in = work_bits_ff >> take;
         work_left_in = work_left_ff - COUNT_BITS'(take);
         if (emit) begin
            if (emit_last) begin
               pending_in = '0;
               fill_in    = '0;
               hits_in    = '0;
            end else begin
               pending_in = window[15:8];
               fill_in    = 3'(total - 4'd8);
               hits_in    = emit_hits;
            end
         end else begin
            pending_in = window[7:0];
            fill_in    = 3'(total);
         end
         if (entry_done) begin
            work_valid_in = 1'b0;
         end
      end
      if (q_pop) begin
         work_valid_in = 1'b1;
         work_bits_in  = q_match;
         work_left_in  = q_take;
         work_last_in  = q_last;
      end
      if (scan_clear) begin
         pending_in = '0;
         fill_in    = '0;
         hits_in    = '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_hits_in  = out_hits_ff;
      out_last_in  = out_last_ff;
      if (out_free) begin
         out_valid_in = emit;
         if (emit) begin
            out_byte_in = window[7:0];
            out_hits_in = emit_hits;
            out_last_in = emit_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         fill_ff       <= '0;
         pending_ff    <= '0;
         hits_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         fill_ff       <= fill_in;
         pending_ff    <= pending_in;
         hits_ff       <= hits_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_bits_ff <= work_bits_in;
      work_left_ff <= work_left_in;
      work_last_ff <= work_last_in;
      out_byte_ff  <= out_byte_in;
      out_hits_ff  <= out_hits_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_match_byte = out_byte_ff;
   assign rsp_hit_total  = out_hits_ff;
   assign rsp_last       = out_last_ff;

endmodule

// ----- rtl/core/packed_column_equality_scan.sv -----
// Scans a bit-packed column for values equal to a key. One packed word is
// accepted per cycle unless the queue pushes back: the front registers it
// joined to the carried bits, then unpacks and compares its elements and
// places the match flags in a four-entry queue. The back packs the flags
// into bytes with the running hit count and emits at most one byte per
// cycle, retiring up to fifteen flags a cycle, so narrow elements can fill
// the queue. A word's first byte is registered at the output after the
// front register, the queue and the back's work register. The scan ends
// after element_count elements with a last byte; the rest of that word is
// dropped and the next word starts a new scan. Writing bits_per_element or
// element_count abandons the scan in progress.
module packed_column_equality_scan #(
   parameter int WORD_BITS = 64,
   parameter int MAX_ELEMENT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [63:0]                          req_packed_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_match_byte,
   output logic [31:0]                          rsp_hit_total,
   output logic                                 rsp_last,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [pces_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [pces_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [pces_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);
   import pces_pkg::*;

   localparam int COUNT_BITS = $clog2(WORD_BITS + 1);
   localparam int ENTRY_BITS = WORD_BITS + COUNT_BITS + 1;

   logic [4:0]            bpe_ff, bpe_in;
   logic [15:0]           key_ff, key_in;
   logic [31:0]           count_ff, count_in;
   logic                  csr_write, scan_clear;
   pces_reg_type          csr_index;
   pces_cfg_type          cfg;
   pces_queue_status_type q_status;
   logic                  q_push, q_pop;
   logic [WORD_BITS-1:0]  push_match, pop_match;
   logic [COUNT_BITS-1:0] push_take, pop_take;
   logic                  push_last, pop_last;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = pces_reg_type'(paddr[3:2]);

   always_comb begin
      bpe_in     = bpe_ff;
      key_in     = key_ff;
      count_in   = count_ff;
      scan_clear = 1'b0;
      if (csr_write) begin
         case (csr_index)
            REG_BITS_PER_ELEMENT: begin
               bpe_in     = pwdata[4:0];
               scan_clear = 1'b1;
            end
            REG_MATCH_KEY: begin
               key_in = pwdata[15:0];
            end
            REG_ELEMENT_COUNT: begin
               count_in   = pwdata;
               scan_clear = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_BITS_PER_ELEMENT: prdata = 32'(bpe_ff);
         REG_MATCH_KEY:        prdata = 32'(key_ff);
         REG_ELEMENT_COUNT:    prdata = count_ff;
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpe_ff   <= 5'd8;
         key_ff   <= 16'd0;
         count_ff <= 32'd1;
      end else begin
         bpe_ff   <= bpe_in;
         key_ff   <= key_in;
         count_ff <= count_in;
      end
   end

   assign cfg.bits_per_element = bpe_ff;
   assign cfg.match_key        = key_ff;
   assign cfg.element_count    = count_ff;

   pces_front #(
      .WORD_BITS        (WORD_BITS),
      .MAX_ELEMENT_BITS (MAX_ELEMENT_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .scan_clear      (scan_clear),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_packed_word (req_packed_word),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_match         (push_match),
      .q_take          (push_take),
      .q_last          (push_last)
   );

   pces_queue #(
      .DATA_BITS (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_match, push_take, push_last}),
      .pop       (q_pop),
      .pop_data  ({pop_match, pop_take, pop_last}),
      .status    (q_status)
   );

   pces_back #(
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .scan_clear     (scan_clear),
      .q_status       (q_status),
      .q_pop          (q_pop),
      .q_match        (pop_match),
      .q_take         (pop_take),
      .q_last         (pop_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_match_byte (rsp_match_byte),
      .rsp_hit_total  (rsp_hit_total),
      .rsp_last       (rsp_last)
   );

   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_status.full)
      else $error("Word pushed into a full match queue.");

   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_status.empty)
      else $error("Match queue popped while empty.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_match_byte)
                                    && $stable(rsp_hit_total) && $stable(rsp_last)))
      else $error("Result transfer changed while stalled.");

endmodule
